FILE: sv/sau_pkg.sv
// Shared types and constants for the stack arithmetic unit.
// Depends on nothing; used by sau_ctrl, sau_dp and stack_arithmetic_unit.
package sau_pkg;

	localparam int WORD_W      = 32;
	localparam int DEPTH_OUT_W = 7;
	localparam int OP_W        = 3;
	localparam int CNT_W       = 5;   // counts the quotient bits of one divide

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_MOD  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_DIVZERO   = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_POPRD,
		S_DIV,
		S_FIX,
		S_DONE
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic    load_in;      // latch the accepted beat
		logic    push;         // spill top into memory, top <= push value
		logic    clear;        // empty the stack
		logic    rd_s;         // read the entry under the top
		logic    rd_pop;       // read the entry three down
		logic    alu_wr;       // top <= s op t for add, subtract, multiply
		logic    div_start;    // load divider with operand magnitudes
		logic    div_step;     // one quotient bit
		logic    pop2;         // drop both operands
		logic    tos_from_rd;  // top <= read data
		logic    fix;          // top <= signed quotient or remainder
		logic    set_status;
		status_t status_code;
		logic    out_load;     // capture the result beat
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  func;
		logic full;
		logic lt2;
		logic ge3;
		logic t_zero;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

FILE: sv/sau_ctrl.sv
// Sequencer for the stack arithmetic unit: walks each item through decode,
// operand read, ALU or divide, and result hand-off. Depends on sau_pkg.
module sau_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sau_pkg::stat_t  st,
	output sau_pkg::cmd_t   cmd
);

	sau_pkg::ctrl_state_t state_q, state_d;
	logic is_bin, is_divmod;

	assign is_bin    = st.func inside {[sau_pkg::OP_ADD:sau_pkg::OP_MOD]};
	assign is_divmod = st.func inside {sau_pkg::OP_DIV, sau_pkg::OP_MOD};
	assign in_ready  = (state_q == sau_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sau_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sau_pkg::S_IDLE: begin
				if (in_valid) state_d = sau_pkg::S_DECODE;
			end
			sau_pkg::S_DECODE: begin
				if (is_bin && !st.lt2) state_d = sau_pkg::S_READ;
				else state_d = sau_pkg::S_DONE;
			end
			sau_pkg::S_READ: begin
				if (is_divmod && st.t_zero) begin
					state_d = st.ge3 ? sau_pkg::S_POPRD : sau_pkg::S_DONE;
				end else if (is_divmod) begin
					state_d = sau_pkg::S_DIV;
				end else begin
					state_d = sau_pkg::S_DONE;
				end
			end
			sau_pkg::S_POPRD: state_d = sau_pkg::S_DONE;
			sau_pkg::S_DIV: begin
				if (st.div_last) state_d = sau_pkg::S_FIX;
			end
			sau_pkg::S_FIX: state_d = sau_pkg::S_DONE;
			sau_pkg::S_DONE: begin
				if (st.out_free) state_d = sau_pkg::S_IDLE;
			end
			default: state_d = sau_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.status_code = sau_pkg::ST_OK;
		case (state_q)
			sau_pkg::S_IDLE: begin
				cmd.load_in = in_valid;
			end
			sau_pkg::S_DECODE: begin
				cmd.set_status = 1'b1;
				if (st.func == sau_pkg::OP_PUSH) begin
					if (st.full) cmd.status_code = sau_pkg::ST_OVERFLOW;
					else cmd.push = 1'b1;
				end else if (is_bin) begin
					if (st.lt2) begin
						cmd.clear       = 1'b1;
						cmd.status_code = sau_pkg::ST_UNDERFLOW;
					end else begin
						cmd.rd_s = 1'b1;
					end
				end
			end
			sau_pkg::S_READ: begin
				if (is_divmod && st.t_zero) begin
					cmd.pop2        = 1'b1;
					cmd.rd_pop      = st.ge3;
					cmd.set_status  = 1'b1;
					cmd.status_code = sau_pkg::ST_DIVZERO;
				end else if (is_divmod) begin
					cmd.div_start = 1'b1;
				end else begin
					cmd.alu_wr = 1'b1;
				end
			end
			sau_pkg::S_POPRD: cmd.tos_from_rd = 1'b1;
			sau_pkg::S_DIV:   cmd.div_step    = 1'b1;
			sau_pkg::S_FIX:   cmd.fix         = 1'b1;
			sau_pkg::S_DONE:  cmd.out_load    = st.out_free;
			default: ;
		endcase
	end

endmodule

FILE: sv/sau_dp.sv
// Datapath of the stack arithmetic unit: stack memory with a cached top,
// adder, multiplier, bit-serial divider and result register. Depends on sau_pkg.
module sau_dp #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sau_pkg::cmd_t                          cmd,
	output sau_pkg::stat_t                         st,
	input  logic [sau_pkg::OP_W-1:0]               in_func,
	input  logic [sau_pkg::WORD_W-1:0]             in_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [1:0]                             out_status,
	output logic [sau_pkg::WORD_W-1:0]             out_top,
	output logic [sau_pkg::DEPTH_OUT_W-1:0]        out_depth
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int W  = sau_pkg::WORD_W;

	// entries below the top; the top itself lives in tos_q
	logic [W-1:0]  mem [STACK_DEPTH];
	logic [W-1:0]  rd_q;
	logic [W-1:0]  tos_q;
	logic [W-1:0]  pv_q;
	sau_pkg::op_t  func_q;
	logic [DW-1:0] depth_q;
	sau_pkg::status_t status_q;

	logic [W-1:0]  rem_q, quo_q, dvs_q;
	logic          rneg_q, qneg_q;
	logic [sau_pkg::CNT_W-1:0] cnt_q;

	logic [DW-1:0] dm1, dm2, dm3;
	logic [AW-1:0] rd_addr;
	logic [W-1:0]  alu_res, prod, s_mag, t_mag, fixed;
	logic [W:0]    trial;

	assign dm1 = depth_q - DW'(1);
	assign dm2 = depth_q - DW'(2);
	assign dm3 = depth_q - DW'(3);
	assign rd_addr = cmd.rd_pop ? dm3[AW-1:0] : dm2[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.push && depth_q != '0) mem[dm1[AW-1:0]] <= tos_q;
		if (cmd.rd_s || cmd.rd_pop) rd_q <= mem[rd_addr];
	end

	assign prod = rd_q * tos_q;

	always_comb begin
		case (func_q)
			sau_pkg::OP_ADD: alu_res = rd_q + tos_q;
			sau_pkg::OP_SUB: alu_res = rd_q - tos_q;
			sau_pkg::OP_MUL: alu_res = prod;
			default:         alu_res = '0;
		endcase
	end

	assign s_mag = rd_q[W-1]  ? (W'(0) - rd_q)  : rd_q;
	assign t_mag = tos_q[W-1] ? (W'(0) - tos_q) : tos_q;
	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	always_comb begin
		if (func_q == sau_pkg::OP_DIV) fixed = qneg_q ? (W'(0) - quo_q) : quo_q;
		else fixed = rneg_q ? (W'(0) - rem_q) : rem_q;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= sau_pkg::op_t'(in_func);
			pv_q   <= in_value;
		end
		if (cmd.set_status) status_q <= cmd.status_code;
		if (cmd.push) tos_q <= pv_q;
		else if (cmd.alu_wr) tos_q <= alu_res;
		else if (cmd.tos_from_rd) tos_q <= rd_q;
		else if (cmd.fix) tos_q <= fixed;
		if (cmd.div_start) begin
			rem_q  <= '0;
			quo_q  <= s_mag;
			dvs_q  <= t_mag;
			rneg_q <= rd_q[W-1];
			qneg_q <= rd_q[W-1] ^ tos_q[W-1];
			cnt_q  <= '1;
		end else if (cmd.div_step) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
			cnt_q <= cnt_q - sau_pkg::CNT_W'(1);
		end
		if (cmd.out_load) begin
			out_status <= status_q;
			out_top    <= (depth_q != '0) ? tos_q : '0;
			out_depth  <= sau_pkg::DEPTH_OUT_W'(depth_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.clear) depth_q <= '0;
			else if (cmd.push) depth_q <= depth_q + DW'(1);
			else if (cmd.alu_wr || cmd.fix) depth_q <= dm1;
			else if (cmd.pop2) depth_q <= dm2;
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	assign st.func     = func_q;
	assign st.full     = (depth_q == DW'(STACK_DEPTH));
	assign st.lt2      = (depth_q < DW'(2));
	assign st.ge3      = (depth_q >= DW'(3));
	assign st.t_zero   = (tos_q == '0);
	assign st.div_last = (cnt_q == '0);
	assign st.out_free = !out_valid || out_ready;

endmodule

FILE: sv/stack_arithmetic_unit.sv
// Top level of the stack arithmetic unit: stream ports around the sequencer
// and datapath. Depends on sau_pkg, sau_ctrl and sau_dp.
//
//  port group  dir  beat contents (low bit up)
//  s_*         in   tuser: func[2:0]; tdata: push_value[31:0]
//  m_*         out  tdata: status[1:0], top_value[33:2], stack_depth[40:34], zero fill
//
// After accept and decode, push, no-op and underflow go to the result; add,
// subtract and multiply read an operand, a zero divisor reads and pops; divide
// and modulo take one quotient bit per cycle, then a sign fix.
// One item is in work at a time; a new one is accepted once the previous
// result sits in the output register, even if it has not been taken yet.
// A result that cannot be loaded holds the unit in its last cycle.
// arst_n empties the stack; memory contents are not cleared.
module stack_arithmetic_unit #(
	parameter int STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // push_value[31:0]
	input  logic [2:0]  s_tuser,   // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // status[1:0], top_value[33:2], stack_depth[40:34]
);

	sau_pkg::cmd_t  cmd;
	sau_pkg::stat_t st;
	logic [1:0]     status;
	logic [31:0]    top_value;
	logic [6:0]     stack_depth;

	sau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	sau_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.in_func    (s_tuser),
		.in_value   (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (status),
		.out_top    (top_value),
		.out_depth  (stack_depth)
	);

	assign m_tdata = {7'd0, stack_depth, top_value, status};

endmodule
